// ----- design/cfb_pkg.sv -----
`default_nettype none
package cfb_pkg;

  localparam int unsigned MaxPayload = 128;

  localparam logic [7:0] Sync0       = 8'hA6;
  localparam logic [7:0] Sync1       = 8'h59;
  localparam logic [7:0] RegAddr     = 8'h01;
  localparam logic [7:0] LenOverhead = 8'd11;
  localparam logic [7:0] TailY       = 8'h59;
  localparam logic [7:0] TailH       = 8'h48;
  localparam logic [7:0] TailT       = 8'h54;

  localparam logic [7:0] DeviceReset  = 8'd2;
  localparam logic [7:0] CommandReset = 8'd1;
  localparam logic [7:0] LengthReset  = 8'd36;

  // Configuration register indexes
  localparam logic [1:0] RegDevice  = 2'd0;
  localparam logic [1:0] RegCommand = 2'd1;
  localparam logic [1:0] RegLength  = 2'd2;

  // Output sequence positions within one frame
  localparam logic [3:0] StepSync0   = 4'd0;
  localparam logic [3:0] StepSync1   = 4'd1;
  localparam logic [3:0] StepLen     = 4'd2;
  localparam logic [3:0] StepDevice  = 4'd3;
  localparam logic [3:0] StepCommand = 4'd4;
  localparam logic [3:0] StepAddr    = 4'd5;
  localparam logic [3:0] StepPayload = 4'd6;
  localparam logic [3:0] StepSumHi   = 4'd7;
  localparam logic [3:0] StepSumLo   = 4'd8;
  localparam logic [3:0] StepY       = 4'd9;
  localparam logic [3:0] StepH       = 4'd10;
  localparam logic [3:0] StepT       = 4'd11;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] len_byte;
    logic [7:0] device;
    logic [7:0] command;
  } hdr_t;

endpackage
`default_nettype wire

// ----- design/cfb_front.sv -----
`default_nettype none
module cfb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    payload_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output cfb_pkg::item_t     q_item,
  output cfb_pkg::hdr_t      hdr
);

  logic [7:0] device_code;
  logic [7:0] command_code;
  logic [7:0] payload_length;
  logic [7:0] bytes_taken;
  logic [7:0] bytes_taken_next;
  logic       len_ok;
  logic       accept;
  logic       frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_code    <= cfb_pkg::DeviceReset;
      command_code   <= cfb_pkg::CommandReset;
      payload_length <= cfb_pkg::LengthReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfb_pkg::RegDevice:  device_code    <= cfg_data;
        cfb_pkg::RegCommand: command_code   <= cfg_data;
        cfb_pkg::RegLength:  payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_ok = (payload_length != 8'd0) &&
                  ({1'b0, payload_length} <= 9'(cfb_pkg::MaxPayload));
  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  // close the frame once the count reaches the length, also if it shrank
  assign frame_last = ({1'b0, bytes_taken} + 9'd1) >= {1'b0, payload_length};

  always_comb begin
    bytes_taken_next = bytes_taken;
    if (accept && len_ok) begin
      bytes_taken_next = frame_last ? 8'd0 : bytes_taken + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken <= 8'd0;
    end else begin
      bytes_taken <= bytes_taken_next;
    end
  end

  // drop items while the length is out of range
  assign q_push       = accept && len_ok;
  assign q_item.data  = payload_byte;
  assign q_item.first = (bytes_taken == 8'd0);
  assign q_item.last  = frame_last;

  assign hdr.len_byte = payload_length + cfb_pkg::LenOverhead;
  assign hdr.device   = device_code;
  assign hdr.command  = command_code;

endmodule
`default_nettype wire

// ----- design/cfb_queue.sv -----
`default_nettype none
module cfb_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cfb_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output cfb_pkg::item_t     head
);

  cfb_pkg::item_t                  entries [cfb_pkg::QueueDepth];
  logic [cfb_pkg::QueuePtrW-1:0]   wr_ptr;
  logic [cfb_pkg::QueuePtrW-1:0]   rd_ptr;
  logic [cfb_pkg::QueuePtrW:0]     count;

  assign full      = (count == (cfb_pkg::QueuePtrW+1)'(cfb_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/cfb_back.sv -----
`default_nettype none
module cfb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfb_pkg::hdr_t hdr,
  input  wire logic          q_not_empty,
  input  wire cfb_pkg::item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         frame_byte,
  output logic               frame_end
);

  logic        in_progress;
  logic [3:0]  step;
  logic [3:0]  cur_step;
  logic [3:0]  end_step;
  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic        load;
  logic [7:0]  byte_sel;
  logic        add_sel;

  assign load     = q_not_empty && (!out_valid || out_ready);
  assign cur_step = in_progress ? step :
                    (q_head.first ? cfb_pkg::StepSync0 : cfb_pkg::StepPayload);
  assign end_step = q_head.last ? cfb_pkg::StepT : cfb_pkg::StepPayload;
  assign q_pop    = load && (cur_step == end_step);

  always_comb begin
    byte_sel = 8'd0;
    add_sel  = 1'b0;
    unique case (cur_step)
      cfb_pkg::StepSync0:   begin byte_sel = cfb_pkg::Sync0;     add_sel = 1'b1; end
      cfb_pkg::StepSync1:   begin byte_sel = cfb_pkg::Sync1;     add_sel = 1'b1; end
      cfb_pkg::StepLen:     begin byte_sel = hdr.len_byte;       add_sel = 1'b1; end
      cfb_pkg::StepDevice:  begin byte_sel = hdr.device;         add_sel = 1'b1; end
      cfb_pkg::StepCommand: begin byte_sel = hdr.command;        add_sel = 1'b1; end
      cfb_pkg::StepAddr:    begin byte_sel = cfb_pkg::RegAddr;   add_sel = 1'b1; end
      cfb_pkg::StepPayload: begin byte_sel = q_head.data;        add_sel = 1'b1; end
      cfb_pkg::StepSumHi:   byte_sel = running_sum[15:8];
      cfb_pkg::StepSumLo:   byte_sel = running_sum[7:0];
      cfb_pkg::StepY:       byte_sel = cfb_pkg::TailY;
      cfb_pkg::StepH:       byte_sel = cfb_pkg::TailH;
      cfb_pkg::StepT:       byte_sel = cfb_pkg::TailT;
      default: ;
    endcase
  end

  always_comb begin
    running_sum_next = running_sum;
    if (load && add_sel) begin
      // restart the sum on the first header byte
      if (cur_step == cfb_pkg::StepSync0) begin
        running_sum_next = {8'd0, byte_sel};
      end else begin
        running_sum_next = running_sum + {8'd0, byte_sel};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_progress <= 1'b0;
      step        <= cfb_pkg::StepSync0;
      running_sum <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      running_sum <= running_sum_next;
      if (load) begin
        out_valid <= 1'b1;
        if (cur_step == end_step) begin
          in_progress <= 1'b0;
        end else begin
          in_progress <= 1'b1;
          step        <= cur_step + 4'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte <= byte_sel;
      frame_end  <= (cur_step == cfb_pkg::StepT);
    end
  end

endmodule
`default_nettype wire

// ----- design/checksum_frame_builder_core.sv -----
// The first output byte of an item passes through the queue and the output register.
// Throughput: one output byte per cycle while out_ready is high, set by the single output
// byte register; a mid-frame item gives its payload byte, the first item of a frame the
// header first, the last checksum and tail after it; a 4-entry queue buffers items.
// Reset: synchronous; registers return to device 2, command 1, length 36, empty queue.
`default_nettype none
module checksum_frame_builder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] payload_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      frame_byte,
  output logic            frame_end
);

  cfb_pkg::item_t q_item;
  cfb_pkg::item_t q_head;
  cfb_pkg::hdr_t  hdr;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_not_empty;

  cfb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .payload_byte (payload_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item),
    .hdr          (hdr)
  );

  cfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  cfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .hdr         (hdr),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .frame_end   (frame_end)
  );

endmodule
`default_nettype wire
